### hw/rtl/swtl_pkg.sv
package swtl_pkg;

  // Field widths of one beat
  localparam int IDX_W        = 14;
  localparam int LOW_W        = 60;
  localparam int HIGH_W       = 15;
  localparam int LEN_W        = 4;
  localparam int COUNT_W      = 15;
  localparam int CODE_W       = 5;
  localparam int LOW_LETTERS  = 12;
  localparam int LETTER_SLOTS = 15;
  localparam int KEY_W        = CODE_W * LETTER_SLOTS;

  // Stream packing
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 16;
  localparam int IDX_LSB    = 0;
  localparam int LOW_LSB    = IDX_LSB + IDX_W;
  localparam int HIGH_LSB   = LOW_LSB + LOW_W;
  localparam int LEN_LSB    = HIGH_LSB + HIGH_W;

  // Command codes carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [LOW_W-1:0]  letters_low;
    logic [HIGH_W-1:0] letters_high;
    logic [LEN_W-1:0]  length;
  } entry_t;

  // Order of the query word against a table word
  typedef enum logic [1:0] {
    ORD_LESS,
    ORD_EQUAL,
    ORD_GREATER
  } order_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  // Pick one letter code out of a word
  function automatic logic [CODE_W-1:0] letter_at(entry_t e, int unsigned i);
    logic [CODE_W-1:0] c;
    if (i < LOW_LETTERS) begin
      c = e.letters_low[CODE_W*i +: CODE_W];
    end else begin
      c = e.letters_high[CODE_W*(i-LOW_LETTERS) +: CODE_W];
    end
    return c;
  endfunction

endpackage

### hw/rtl/sorted_word_table_lookup.sv
// Load beat: written to the table on the accepting edge; input ready stays high.
// Query beat: one probe per cycle through the registered table read, at most
// ceil(log2(n+1)) probes for n searched entries (15 at 16384 entries); the
// answer is registered from the compare of the last probe, or from the accepted
// beat itself for an empty table, and is parked while the output is stalled.
// Reset (rst, synchronous): clears control state and word_count; table contents stay as they were.
module sorted_word_table_lookup import swtl_pkg::*; #(
  parameter int TABLE_DEPTH = 16384,
  parameter int MAX_LETTERS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data,    // word_count
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index[13:0], letters_low[73:14], letters_high[88:74], word_length[92:89]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,   // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // match_index[13:0]
  output logic                  m_axis_tuser    // found
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;

  swtl_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  swtl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_LETTERS (MAX_LETTERS),
    .AW          (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

endmodule

### hw/rtl/swtl_mem.sv
module swtl_mem import swtl_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/swtl_cmp.sv
module swtl_cmp import swtl_pkg::*; (
  input  entry_t query,
  input  entry_t entry,
  output order_t ord
);

  logic [LEN_W-1:0] n;
  logic [KEY_W-1:0] qkey;
  logic [KEY_W-1:0] ekey;

  // Line letters up with letter 0 most significant, blank past the shorter length
  always_comb begin
    n = (query.length < entry.length) ? query.length : entry.length;
    for (int i = 0; i < LETTER_SLOTS; i++) begin
      if (LEN_W'(i) < n) begin
        qkey[KEY_W-1-CODE_W*i -: CODE_W] = letter_at(query, i);
        ekey[KEY_W-1-CODE_W*i -: CODE_W] = letter_at(entry, i);
      end else begin
        qkey[KEY_W-1-CODE_W*i -: CODE_W] = '0;
        ekey[KEY_W-1-CODE_W*i -: CODE_W] = '0;
      end
    end
  end

  // Letters decide first, then the shorter word sorts first
  always_comb begin
    if (qkey < ekey) begin
      ord = ORD_LESS;
    end else if (qkey > ekey) begin
      ord = ORD_GREATER;
    end else if (query.length < entry.length) begin
      ord = ORD_LESS;
    end else if (query.length > entry.length) begin
      ord = ORD_GREATER;
    end else begin
      ord = ORD_EQUAL;
    end
  end

endmodule

### hw/rtl/swtl_ctrl.sv
module swtl_ctrl import swtl_pkg::*; #(
  parameter int TABLE_DEPTH = 16384,
  parameter int MAX_LETTERS = 15,
  parameter int AW          = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output entry_t                mem_wr_data,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  entry_t                mem_rd_data
);

  // Bounds run up to the depth itself, so one bit more than an address
  localparam int NW = AW + 1;
  localparam int SW = NW + 1;
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int IW = (NW > IDX_W + 1) ? NW : IDX_W + 1;

  state_t              state;
  state_t              state_next;
  logic [COUNT_W-1:0]  word_count;
  entry_t              query;
  entry_t              in_entry;
  logic [LEN_W-1:0]    in_len;
  logic [NW-1:0]       lo_b;
  logic [NW-1:0]       hi_b;
  logic [AW-1:0]       cur_mid;
  logic [NW-1:0]       lo_b_next;
  logic [NW-1:0]       hi_b_next;
  logic [AW-1:0]       cur_mid_next;
  logic                pend_found;
  logic [IDX_W-1:0]    pend_idx;
  logic                out_found;
  logic [IDX_W-1:0]    out_idx;
  logic                acc;
  logic                is_query;
  logic [IW-1:0]       idx_ext;
  logic [CW-1:0]       count_ext;
  logic [NW-1:0]       n;
  logic [AW-1:0]       start_mid;
  logic [NW-1:0]       mid_ext;
  logic [NW-1:0]       gt_lo;
  logic                gt_empty;
  logic [AW-1:0]       gt_mid;
  logic                lt_empty;
  logic [AW-1:0]       lt_mid;
  logic                out_free;
  logic                fin;
  logic                fin_found;
  logic [IDX_W-1:0]    fin_idx;
  logic                query_load;
  logic                out_load;
  logic                pend_load;
  logic                out_src_pend;
  order_t              ord;

  swtl_cmp u_cmp (
    .query (query),
    .entry (mem_rd_data),
    .ord   (ord)
  );

  // Unpack the input beat and clamp the length
  always_comb begin
    in_len = s_axis_tdata[LEN_LSB +: LEN_W];
    if (in_len > LEN_W'(MAX_LETTERS)) begin
      in_len = LEN_W'(MAX_LETTERS);
    end
    in_entry.letters_low  = s_axis_tdata[LOW_LSB +: LOW_W];
    in_entry.letters_high = s_axis_tdata[HIGH_LSB +: HIGH_W];
    in_entry.length       = in_len;
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_query      = (s_axis_tuser == CMD_QUERY);

  // Loads go straight to the table; out-of-range indexes are dropped
  assign idx_ext     = IW'(s_axis_tdata[IDX_LSB +: IDX_W]);
  assign mem_wr_en   = acc && !is_query && (idx_ext < IW'(TABLE_DEPTH));
  assign mem_wr_addr = AW'(idx_ext);
  assign mem_wr_data = in_entry;

  // Entries searched: word_count capped at the depth
  assign count_ext = CW'(word_count);
  assign n         = (count_ext > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_ext);
  assign start_mid = AW'((n - NW'(1)) >> 1);

  // Both candidate next probes, worked out alongside the compare
  assign mid_ext  = NW'(cur_mid);
  assign gt_lo    = mid_ext + NW'(1);
  assign gt_empty = (gt_lo >= hi_b);
  assign gt_mid   = AW'((SW'(mid_ext) + SW'(hi_b)) >> 1);
  assign lt_empty = (lo_b >= mid_ext);
  assign lt_mid   = AW'((SW'(lo_b) + SW'(mid_ext) - SW'(1)) >> 1);

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state, probe address and finish event
  always_comb begin
    state_next   = state;
    lo_b_next    = lo_b;
    hi_b_next    = hi_b;
    cur_mid_next = cur_mid;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = start_mid;
    fin          = 1'b0;
    fin_found    = 1'b0;
    fin_idx      = '0;
    query_load   = 1'b0;
    out_load     = 1'b0;
    pend_load    = 1'b0;
    out_src_pend = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (acc && is_query) begin
          query_load = 1'b1;
          lo_b_next  = '0;
          hi_b_next  = n;
          if (n == '0) begin
            fin = 1'b1;
          end else begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = start_mid;
            cur_mid_next = start_mid;
            state_next   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        unique case (ord)
          ORD_EQUAL: begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_idx   = IDX_W'(cur_mid);
          end
          ORD_GREATER: begin
            if (gt_empty) begin
              fin = 1'b1;
            end else begin
              lo_b_next    = gt_lo;
              mem_rd_en    = 1'b1;
              mem_rd_addr  = gt_mid;
              cur_mid_next = gt_mid;
            end
          end
          ORD_LESS: begin
            if (lt_empty) begin
              fin = 1'b1;
            end else begin
              hi_b_next    = mid_ext;
              mem_rd_en    = 1'b1;
              mem_rd_addr  = lt_mid;
              cur_mid_next = lt_mid;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_src_pend = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Hand a finished answer to the output, or park it while the output is full
    if (fin) begin
      if (out_free) begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        pend_load  = 1'b1;
        state_next = ST_HOLD;
      end
    end
  end

  // State, output valid and word_count
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      word_count    <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        word_count <= cfg_wr_data;
      end
    end
  end

  // Search bounds, query word and answers
  always_ff @(posedge clk) begin
    lo_b    <= lo_b_next;
    hi_b    <= hi_b_next;
    cur_mid <= cur_mid_next;
    if (query_load) begin
      query <= in_entry;
    end
    if (pend_load) begin
      pend_found <= fin_found;
      pend_idx   <= fin_idx;
    end
    if (out_load) begin
      out_found <= out_src_pend ? pend_found : fin_found;
      out_idx   <= out_src_pend ? pend_idx : fin_idx;
    end
  end

  assign m_axis_tuser = out_found;
  assign m_axis_tdata = OUT_DATA_W'(out_idx);

endmodule

### hw/rtl/swtl_checker.sv
module swtl_checker import swtl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wr_en,
  input logic [COUNT_W-1:0]    cfg_wr_data,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // Hold a stalled result beat unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Drop input ready only after a query beat was taken
  a_busy_after_query: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == CMD_QUERY))
    else $error("input stalled without a query beat");

  // A load beat never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD && !m_axis_tvalid |=>
      !m_axis_tvalid)
    else $error("result beat after a load");

  // A miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with non-zero index");

endmodule

bind sorted_word_table_lookup swtl_checker u_swtl_checker (.*);
